FILE: hw/rtl/cobsd_pkg.sv
// cobsd_pkg: shared constants, state type and decode status struct for the COBS frame decoder.
// Used by cobsd_decode and cobs_frame_decoder; depends on nothing.
`timescale 1ns / 1ps

package cobsd_pkg;

    localparam int STORE_DEPTH_DEF = 128;
    localparam int PAYLOAD_MAX_DEF = 64;

    localparam int          HDR_LEN      = 5;
    localparam logic [7:0]  NO_ZERO_CODE = 8'd255;

    typedef enum logic [2:0] {
        ST_RX  = 3'b001,
        ST_DEC = 3'b010,
        ST_OUT = 3'b100
    } state_t;

    typedef struct packed {
        logic        done;
        logic        ok;
        logic [7:0]  version;
        logic [7:0]  command;
        logic [15:0] seq;
        logic [6:0]  plen;
    } status_t;

endpackage

FILE: hw/rtl/cobsd_decode.sv
// cobsd_decode: encoded frame memory, COBS decode walk, header registers and payload memory.
// Depends on cobsd_pkg.
`timescale 1ns / 1ps

module cobsd_decode #(
    parameter int STORE_DEPTH = cobsd_pkg::STORE_DEPTH_DEF,
    parameter int PAYLOAD_MAX = cobsd_pkg::PAYLOAD_MAX_DEF,
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1),
    localparam int EA_W   = $clog2(STORE_DEPTH),
    localparam int PIDX_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [EA_W-1:0]      wr_addr,
    input  logic [7:0]           wr_data,
    input  logic                 start,
    input  logic [CNT_W-1:0]     size,
    input  logic                 rd_en,
    input  logic [PIDX_W-1:0]    rd_idx,
    output logic [7:0]           rd_data,
    output cobsd_pkg::status_t   status
);

    localparam int RAW_CAP = cobsd_pkg::HDR_LEN + PAYLOAD_MAX;
    localparam int USED_W  = $clog2(RAW_CAP + 1);
    localparam int SUM_W   = ((USED_W > 8) ? USED_W : 8) + 1;

    logic [7:0] emem [0:STORE_DEPTH-1];
    logic [7:0] pmem [0:PAYLOAD_MAX-1];
    logic [7:0] hdr_reg [0:cobsd_pkg::HDR_LEN-1];

    logic              busy_reg;
    logic              rv_reg;
    logic              chk_reg;
    logic              done_reg;
    logic              ok_reg;
    logic              zflag_reg;
    logic [CNT_W-1:0]  rd_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  size_reg;
    logic [7:0]        cnt_reg;
    logic [USED_W-1:0] used_reg;
    logic [7:0]        ebuf_reg;
    logic [7:0]        pdata_reg;

    logic              rd_go;
    logic              proc;
    logic              code_ph;
    logic [7:0]        byte_m1;
    logic [CNT_W-1:0]  rem;
    logic [USED_W-1:0] u1;
    logic [SUM_W-1:0]  sum;
    logic              zfail;
    logic              fail;
    logic              last_byte;
    logic              w_en;
    logic [7:0]        w_data;
    logic              hdr_ok;

    assign rd_go     = busy_reg && (rd_reg < size_reg);
    assign proc      = busy_reg && rv_reg;
    assign code_ph   = (cnt_reg == 8'd0);
    assign byte_m1   = ebuf_reg - 8'd1;
    assign rem       = size_reg - pos_reg - CNT_W'(1);
    assign u1        = used_reg + USED_W'(zflag_reg);
    assign sum       = SUM_W'(u1) + SUM_W'(byte_m1);
    assign zfail     = zflag_reg && (used_reg == USED_W'(RAW_CAP));
    assign last_byte = (pos_reg == size_reg - CNT_W'(1));

    always_comb
    begin
        fail = 1'b0;
        if (proc && code_ph)
        begin
            fail = zfail || (ebuf_reg == 8'd0) || (byte_m1 > 8'(rem))
                || (sum > SUM_W'(RAW_CAP));
        end
    end

    // a code byte writes the zero that closes the previous block, a data byte writes itself
    assign w_en   = proc && !fail && (code_ph ? zflag_reg : 1'b1);
    assign w_data = code_ph ? 8'd0 : ebuf_reg;

    assign hdr_ok = (used_reg >= USED_W'(cobsd_pkg::HDR_LEN))
        && (hdr_reg[4] <= 8'(PAYLOAD_MAX))
        && (9'(used_reg) == 9'(cobsd_pkg::HDR_LEN) + 9'(hdr_reg[4]));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            emem[wr_addr] <= wr_data;
        end
        if (rd_go)
        begin
            ebuf_reg <= emem[rd_reg[EA_W-1:0]];
        end
        if (w_en)
        begin
            if (used_reg < USED_W'(cobsd_pkg::HDR_LEN))
            begin
                hdr_reg[used_reg[2:0]] <= w_data;
            end
            else
            begin
                pmem[PIDX_W'(used_reg - USED_W'(cobsd_pkg::HDR_LEN))] <= w_data;
            end
        end
        if (rd_en)
        begin
            pdata_reg <= pmem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            rv_reg    <= 1'b0;
            chk_reg   <= 1'b0;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
            zflag_reg <= 1'b0;
            rd_reg    <= '0;
            pos_reg   <= '0;
            size_reg  <= '0;
            cnt_reg   <= '0;
            used_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            ok_reg   <= 1'b0;
            chk_reg  <= 1'b0;
            rv_reg   <= rd_go;
            if (rd_go)
            begin
                rd_reg <= rd_reg + CNT_W'(1);
            end
            if (start)
            begin
                busy_reg  <= 1'b1;
                rv_reg    <= 1'b0;
                zflag_reg <= 1'b0;
                rd_reg    <= '0;
                pos_reg   <= '0;
                size_reg  <= size;
                cnt_reg   <= '0;
                used_reg  <= '0;
            end
            else if (proc)
            begin
                pos_reg <= pos_reg + CNT_W'(1);
                if (code_ph)
                begin
                    cnt_reg   <= byte_m1;
                    zflag_reg <= (ebuf_reg != cobsd_pkg::NO_ZERO_CODE);
                    used_reg  <= u1;
                end
                else
                begin
                    cnt_reg  <= cnt_reg - 8'd1;
                    used_reg <= used_reg + USED_W'(1);
                end
                if (fail)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else if (last_byte)
                begin
                    busy_reg <= 1'b0;
                    chk_reg  <= 1'b1;
                end
            end
            if (chk_reg)
            begin
                done_reg <= 1'b1;
                ok_reg   <= hdr_ok;
            end
        end
    end

    assign rd_data        = pdata_reg;
    assign status.done    = done_reg;
    assign status.ok      = ok_reg;
    assign status.version = hdr_reg[0];
    assign status.command = hdr_reg[1];
    assign status.seq     = {hdr_reg[3], hdr_reg[2]};
    assign status.plen    = 7'(hdr_reg[4]);

endmodule

FILE: hw/rtl/cobs_frame_decoder.sv
// cobs_frame_decoder: top level; receive framing, control sequencer and result word register.
// Depends on cobsd_pkg and cobsd_decode.
// Throughput: one input word per cycle while receiving; input stalls during decode and output.
// Results: each word is loaded after its payload memory read; loading waits on out_stall.
// Reset: rst_n clears fill count, discard flag and sequencer; memories are not cleared.
`timescale 1ns / 1ps

module cobs_frame_decoder #(
    parameter int STORE_DEPTH = cobsd_pkg::STORE_DEPTH_DEF,
    parameter int PAYLOAD_MAX = cobsd_pkg::PAYLOAD_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  version,
    output logic [7:0]  command,
    output logic [15:0] sequence_res,
    output logic [6:0]  payload_length,
    output logic [5:0]  payload_index,
    output logic [7:0]  payload_byte,
    output logic        has_payload,
    output logic        last
);

    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int EA_W   = $clog2(STORE_DEPTH);
    localparam int PIDX_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    cobsd_pkg::state_t  state_reg;
    cobsd_pkg::status_t status;

    logic [CNT_W-1:0] fill_reg;
    logic             discard_reg;
    logic             pend_reg;
    logic [5:0]       idx_reg;
    logic             out_valid_reg;
    logic [7:0]       version_reg;
    logic [7:0]       command_reg;
    logic [15:0]      seq_reg;
    logic [6:0]       plen_reg;
    logic [5:0]       pidx_reg;
    logic [7:0]       pbyte_reg;
    logic             has_reg;
    logic             last_reg;

    logic             in_acc;
    logic             wr_en;
    logic             start;
    logic             rd_en;
    logic [7:0]       rd_data;
    logic             out_free;
    logic             load;
    logic [6:0]       n_res;
    logic             is_last;
    logic             empty_pl;

    assign in_stall = (state_reg != cobsd_pkg::ST_RX);
    assign in_acc   = in_valid && !in_stall;
    assign wr_en    = in_acc && (rx_byte != 8'd0) && !discard_reg
        && (fill_reg < CNT_W'(STORE_DEPTH));
    assign start    = in_acc && (rx_byte == 8'd0) && !discard_reg
        && (fill_reg != '0);

    assign out_free = !out_valid_reg || !out_stall;
    assign rd_en    = (state_reg == cobsd_pkg::ST_OUT) && !pend_reg;
    assign load     = (state_reg == cobsd_pkg::ST_OUT) && pend_reg && out_free;
    assign empty_pl = (status.plen == 7'd0);
    assign n_res    = empty_pl ? 7'd1 : status.plen;
    assign is_last  = ({1'b0, idx_reg} + 7'd1 == n_res);

    cobsd_decode #(
        .STORE_DEPTH (STORE_DEPTH),
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_dec (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[EA_W-1:0]),
        .wr_data (rx_byte),
        .start   (start),
        .size    (fill_reg),
        .rd_en   (rd_en),
        .rd_idx  (idx_reg[PIDX_W-1:0]),
        .rd_data (rd_data),
        .status  (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cobsd_pkg::ST_RX;
            fill_reg      <= '0;
            discard_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                cobsd_pkg::ST_RX:
                begin
                    if (in_acc)
                    begin
                        if (rx_byte == 8'd0)
                        begin
                            fill_reg    <= '0;
                            discard_reg <= 1'b0;
                            if (start)
                            begin
                                state_reg <= cobsd_pkg::ST_DEC;
                            end
                        end
                        else if (wr_en)
                        begin
                            fill_reg <= fill_reg + CNT_W'(1);
                        end
                        else
                        begin
                            discard_reg <= 1'b1;
                        end
                    end
                end
                cobsd_pkg::ST_DEC:
                begin
                    if (status.done)
                    begin
                        idx_reg   <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= status.ok ? cobsd_pkg::ST_OUT : cobsd_pkg::ST_RX;
                    end
                end
                cobsd_pkg::ST_OUT:
                begin
                    if (rd_en)
                    begin
                        pend_reg <= 1'b1;
                    end
                    if (load)
                    begin
                        pend_reg <= 1'b0;
                        idx_reg  <= idx_reg + 6'd1;
                        if (is_last)
                        begin
                            state_reg <= cobsd_pkg::ST_RX;
                        end
                    end
                end
                default:
                begin
                    state_reg <= cobsd_pkg::ST_RX;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            version_reg <= status.version;
            command_reg <= status.command;
            seq_reg     <= status.seq;
            plen_reg    <= status.plen;
            pidx_reg    <= empty_pl ? 6'd0 : idx_reg;
            pbyte_reg   <= empty_pl ? 8'd0 : rd_data;
            has_reg     <= !empty_pl;
            last_reg    <= is_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign version        = version_reg;
    assign command        = command_reg;
    assign sequence_res   = seq_reg;
    assign payload_length = plen_reg;
    assign payload_index  = pidx_reg;
    assign payload_byte   = pbyte_reg;
    assign has_payload    = has_reg;
    assign last           = last_reg;

endmodule
